// ===== design/pps_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_pick and preemptive_priority_scheduler; no dependencies.
package pps_pkg;

  localparam int TIME_W = 24;
  localparam int SUM_W  = 28;
  localparam int CNT_W  = 5;
  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int URG_W  = 8;
  localparam int EIDX_W = 4;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 216;

  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0]  TASK_COUNT_RST = 5'd16;

  // Request kinds carried on in_tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // One task table entry as stored in the table memory
  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [BUR_W-1:0] remaining;
    logic [URG_W-1:0] urgency;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controls from the sequencer to the selection unit
  typedef struct packed {
    logic clr;
    logic vld;
  } pick_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DISPATCH,
    ST_FIN_A,
    ST_FIN_B,
    ST_FIN_C,
    ST_EMIT
  } state_t;

  // Saturating add of a task time into a running total
  function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - TIME_W){1'b0}}, b};
    return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ===== design/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler: a load request writes a task entry, a tick request scans
// the table memory one entry per cycle, limit = min(task_count, MAX_TASKS), and runs the winner.
// One request in flight: a new request is accepted only after the result of the last one
// has moved to the output register; a result waiting on out_tready stalls only the next emit.
// Synchronous active-low reset clears time, the done count, totals, valid bits; task_count is 16.
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // entry_index, arrival_time, burst_time, priority_level (from bit 0)
  input  logic [pps_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // slot_busy, running_index, slot_start, finished, completion_time,
  // turnaround, waiting, response, all_done, sum_turnaround, sum_waiting,
  // sum_response (from bit 0)
  output logic [pps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [pps_pkg::CNT_W-1:0]          cfg_wr_data
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int LIM_W = $clog2(MAX_TASKS + 1);

  // Request fields
  logic [EIDX_W-1:0] in_idx;
  logic [ARR_W-1:0]  in_arr;
  logic [BUR_W-1:0]  in_bur;
  logic [URG_W-1:0]  in_pri;

  assign in_idx = in_tdata[3:0];
  assign in_arr = in_tdata[19:4];
  assign in_bur = in_tdata[35:20];
  assign in_pri = in_tdata[43:36];

  // Control state
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [LIM_W-1:0]       lim_r, lim_nxt;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [CNT_W-1:0]       done_cnt_r, done_cnt_nxt;
  logic [SUM_W-1:0]       tot_turn_r, tot_turn_nxt;
  logic [SUM_W-1:0]       tot_wait_r, tot_wait_nxt;
  logic [SUM_W-1:0]       tot_resp_r, tot_resp_nxt;
  logic [CNT_W-1:0]       task_count_r;
  logic [MAX_TASKS-1:0]   valid_r, valid_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;

  // Result payload
  logic                   first_r, first_nxt;
  logic                   res_busy_r, res_busy_nxt;
  logic [EIDX_W-1:0]      res_run_r, res_run_nxt;
  logic [TIME_W-1:0]      res_start_r, res_start_nxt;
  logic                   res_fin_r, res_fin_nxt;
  logic [TIME_W-1:0]      res_ct_r, res_ct_nxt;
  logic [TIME_W-1:0]      res_tat_r, res_tat_nxt;
  logic [TIME_W-1:0]      res_wt_r, res_wt_nxt;
  logic [TIME_W-1:0]      res_rt_r, res_rt_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Memory ports
  logic              tab_we;
  logic [IDX_W-1:0]  tab_waddr;
  entry_t            tab_wdata;
  entry_t            tab_rdata;
  entry_t            rd_entry;
  logic              resp_we;
  logic [TIME_W-1:0] resp_wdata;
  logic [TIME_W-1:0] resp_rdata;

  // Selection unit
  pick_ctl_t         pick_ctl;
  logic              pick_found;
  logic [IDX_W-1:0]  pick_idx;
  entry_t            pick_best;

  logic [TIME_W-1:0] arr_ext;
  logic [TIME_W-1:0] bur_ext;
  logic [TIME_W-1:0] now_inc;
  logic              all_done;

  assign arr_ext  = {{(TIME_W - ARR_W){1'b0}}, pick_best.arrival};
  assign bur_ext  = {{(TIME_W - BUR_W){1'b0}}, pick_best.burst};
  assign now_inc  = (now_r == TIME_MAX) ? now_r : now_r + 1'b1;
  assign all_done = (done_cnt_r >= task_count_r);

  // Entries never loaded read as zero, so they are never eligible
  assign rd_entry = valid_r[rd_idx_r] ? tab_rdata : '0;

  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (cnt_r),
    .rdata (tab_rdata)
  );

  pps_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_TASKS)
  ) u_resp_ram (
    .clk   (clk),
    .we    (resp_we),
    .waddr (pick_idx),
    .wdata (resp_wdata),
    .raddr (pick_idx),
    .rdata (resp_rdata)
  );

  pps_pick #(
    .MAX_TASKS (MAX_TASKS)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pick_ctl),
    .idx      (rd_idx_r),
    .entry    (rd_entry),
    .now      (now_r),
    .found    (pick_found),
    .best_idx (pick_idx),
    .best     (pick_best)
  );

  // Sequencer: next state, memory accesses and result fields
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    lim_nxt        = lim_r;
    now_nxt        = now_r;
    done_cnt_nxt   = done_cnt_r;
    tot_turn_nxt   = tot_turn_r;
    tot_wait_nxt   = tot_wait_r;
    tot_resp_nxt   = tot_resp_r;
    valid_nxt      = valid_r;
    first_nxt      = first_r;
    res_busy_nxt   = res_busy_r;
    res_run_nxt    = res_run_r;
    res_start_nxt  = res_start_r;
    res_fin_nxt    = res_fin_r;
    res_ct_nxt     = res_ct_r;
    res_tat_nxt    = res_tat_r;
    res_wt_nxt     = res_wt_r;
    res_rt_nxt     = res_rt_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    in_tready      = 1'b0;
    tab_we         = 1'b0;
    tab_waddr      = pick_idx;
    tab_wdata      = pick_best;
    resp_we        = 1'b0;
    resp_wdata     = now_r - arr_ext;
    pick_ctl.clr   = 1'b0;
    pick_ctl.vld   = rd_vld_r;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          res_busy_nxt  = 1'b0;
          res_run_nxt   = '0;
          res_start_nxt = now_r;
          res_fin_nxt   = 1'b0;
          res_ct_nxt    = '0;
          res_tat_nxt   = '0;
          res_wt_nxt    = '0;
          res_rt_nxt    = '0;
          if (in_tuser == ACT_LOAD) begin
            // Write the entry with remaining set to the burst
            if (int'(in_idx) < MAX_TASKS) begin
              tab_we              = 1'b1;
              tab_waddr           = IDX_W'(in_idx);
              tab_wdata.arrival   = in_arr;
              tab_wdata.burst     = in_bur;
              tab_wdata.remaining = in_bur;
              tab_wdata.urgency   = in_pri;
              valid_nxt[IDX_W'(in_idx)] = 1'b1;
            end
            state_nxt = ST_EMIT;
          end else begin
            // Start a scan over entries below the limit
            lim_nxt      = (int'(task_count_r) < MAX_TASKS) ?
                           LIM_W'(task_count_r) : LIM_W'(MAX_TASKS);
            cnt_nxt      = '0;
            pick_ctl.clr = 1'b1;
            state_nxt    = (lim_nxt == '0) ? ST_DISPATCH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Advance the read address one entry per cycle
        if ({1'b0, cnt_r} == lim_r - 1'b1) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        now_nxt = now_inc;
        if (pick_found) begin
          // Run the winner for one tick and write back its remaining count
          res_busy_nxt        = 1'b1;
          res_run_nxt         = EIDX_W'(pick_idx);
          tab_we              = 1'b1;
          tab_wdata.remaining = pick_best.remaining - 1'b1;
          first_nxt           = (pick_best.remaining == pick_best.burst);
          resp_we             = first_nxt;
          if (pick_best.remaining == BUR_W'(1)) begin
            res_fin_nxt = 1'b1;
            state_nxt   = ST_FIN_A;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_FIN_A: begin
        // Completion, turnaround and response times
        res_ct_nxt  = now_r;
        res_tat_nxt = now_r - arr_ext;
        res_rt_nxt  = first_r ? (res_start_r - arr_ext) : resp_rdata;
        state_nxt   = ST_FIN_B;
      end
      ST_FIN_B: begin
        // Waiting time clamps at zero; update turnaround and response totals and done count
        res_wt_nxt   = (res_tat_r >= bur_ext) ? (res_tat_r - bur_ext) : '0;
        tot_turn_nxt = sat_add_sum(tot_turn_r, res_tat_r);
        tot_resp_nxt = sat_add_sum(tot_resp_r, res_rt_r);
        done_cnt_nxt = (done_cnt_r == COUNT_MAX) ? done_cnt_r : done_cnt_r + 1'b1;
        state_nxt    = ST_FIN_C;
      end
      ST_FIN_C: begin
        tot_wait_nxt = sat_add_sum(tot_wait_r, res_wt_r);
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        // Hand the result to the output register once it is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(OUT_TDATA_W - 211){1'b0}},
                            tot_resp_r, tot_wait_r, tot_turn_r, all_done,
                            res_rt_r, res_wt_r, res_tat_r, res_ct_r, res_fin_r,
                            res_start_r, res_run_r, res_busy_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_vld_r     <= 1'b0;
      now_r        <= '0;
      done_cnt_r   <= '0;
      tot_turn_r   <= '0;
      tot_wait_r   <= '0;
      tot_resp_r   <= '0;
      task_count_r <= TASK_COUNT_RST;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= (state_r == ST_SCAN);
      now_r        <= now_nxt;
      done_cnt_r   <= done_cnt_nxt;
      tot_turn_r   <= tot_turn_nxt;
      tot_wait_r   <= tot_wait_nxt;
      tot_resp_r   <= tot_resp_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        task_count_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    lim_r       <= lim_nxt;
    rd_idx_r    <= cnt_r;
    first_r     <= first_nxt;
    res_busy_r  <= res_busy_nxt;
    res_run_r   <= res_run_nxt;
    res_start_r <= res_start_nxt;
    res_fin_r   <= res_fin_nxt;
    res_ct_r    <= res_ct_nxt;
    res_tat_r   <= res_tat_nxt;
    res_wt_r    <= res_wt_nxt;
    res_rt_r    <= res_rt_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_done_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> done_cnt_r >= $past(done_cnt_r))
    else $error("done count went backwards");
  a_fin_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && res_fin_r) |-> res_busy_r)
    else $error("completion reported without a running task");
  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DISPATCH) |=> (now_r != $past(now_r) || now_r == TIME_MAX))
    else $error("tick did not advance time");

endmodule

// ===== design/pps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pps_pick.sv =====
// Selection unit: folds table entries read one per cycle into the best
// eligible task. Depends on pps_pkg.
module pps_pick #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pps_pkg::pick_ctl_t           ctl,
  input  logic [$clog2(MAX_TASKS)-1:0] idx,
  input  pps_pkg::entry_t              entry,
  input  logic [pps_pkg::TIME_W-1:0]   now,
  output logic                         found,
  output logic [$clog2(MAX_TASKS)-1:0] best_idx,
  output pps_pkg::entry_t              best
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           best_r, best_nxt;
  logic             eligible;

  // Arrived, unfinished, and strictly more urgent than the current pick
  always_comb begin
    eligible     = ({{(TIME_W - ARR_W){1'b0}}, entry.arrival} <= now) &&
                   (entry.remaining != '0);
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (ctl.vld && eligible && (!found_r || entry.urgency < best_r.urgency)) begin
      found_nxt    = 1'b1;
      best_idx_nxt = idx;
      best_nxt     = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best     = best_r;

  a_clr_drops: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> !found_r)
    else $error("pick not cleared");
  a_best_live: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> best_r.remaining != '0)
    else $error("picked a finished task");
  a_best_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && !ctl.clr && !ctl.vld) |=> (found_r && $stable(best_idx_r)))
    else $error("pick changed without a request");

endmodule
